FILE: rtl/tcpq_pkg.sv
// package for the two-class priority queue: sizes, command and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tcpq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_SERVED    = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // commands from the control to one queue
  typedef struct packed {
    logic                push;
    logic [TAG_BITS-1:0] push_tag;
    logic                scan;      // find, remove first match, compact
    logic                pop;       // remove head, compact
    logic [TAG_BITS-1:0] key;
  } qctl_t;

  typedef struct packed {
    logic                done;
    logic                found;
    logic [TAG_BITS-1:0] head;
  } qsts_t;
endpackage
`default_nettype wire

FILE: rtl/two_class_priority_queue_with_cancel.sv
// top level: command handshake, tag counter, two tag queues
// depends on tcpq_pkg, tcpq_fifo
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                                      | handshake
// command | start, command, preferred, cancel_tag         | start & !busy & command != CMD_NONE
// result  | strobe, status, tag_out, hit_preferred,       | strobe, one cycle
//         | hit_normal                                   |
// enqueue and a serve of two empty queues go from acceptance straight to T_OUT with the result strobe.
// serve walks one queue memory a slot a cycle; cancel walks both, the preferred queue
// first and then the normal one.
// busy is high from acceptance until the result strobe.
// reset is synchronous and empties both queues and clears the tag counter.
// the result receiver cannot stall.
module two_class_priority_queue_with_cancel import tcpq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          command,
  input  wire logic                preferred,
  input  wire logic [15:0]         cancel_tag,
  output logic                     strobe,
  output logic [2:0]               status,
  output logic [15:0]              tag_out,
  output logic                     hit_preferred,
  output logic                     hit_normal
);
  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_PQ   = 5'b00010,
    T_NQ   = 5'b00100,
    T_WAIT = 5'b01000,
    T_OUT  = 5'b10000
  } tstate_t;

  tstate_t             state;
  qctl_t               pctl, nctl;
  qsts_t               psts, nsts;
  logic [CNT_W-1:0]    pcnt, ncnt;
  logic [TAG_BITS-1:0] last_tag, next_tag, ctag;
  cmd_t                cmd;
  logic                hp;
  logic                accept;

  tcpq_fifo u_pq (.clk(clk), .rst(rst), .ctl(pctl), .count(pcnt), .sts(psts));
  tcpq_fifo u_nq (.clk(clk), .rst(rst), .ctl(nctl), .count(ncnt), .sts(nsts));

  assign accept = start && !busy && (command != CMD_NONE);
  assign busy   = (state != T_IDLE);
  assign next_tag = (last_tag + TAG_BITS'(1) == '0) ? TAG_BITS'(1)
                                                     : last_tag + TAG_BITS'(1);

  always_comb begin
    pctl = '0;
    nctl = '0;
    pctl.key = ctag;
    nctl.key = ctag;
    pctl.push_tag = next_tag;
    nctl.push_tag = next_tag;
    if (state == T_PQ) begin
      if (cmd == CMD_CANCEL) pctl.scan = 1'b1;
      else pctl.pop = 1'b1;
    end
    if (state == T_NQ) begin
      if (cmd == CMD_CANCEL) nctl.scan = 1'b1;
      else nctl.pop = 1'b1;
    end
    if (accept && command == CMD_ENQ) begin
      if (preferred && pcnt < CNT_W'(QUEUE_DEPTH)) pctl.push = 1'b1;
      if (!preferred && ncnt < CNT_W'(QUEUE_DEPTH)) nctl.push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      last_tag <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        T_IDLE: if (accept) begin
          cmd  <= cmd_t'(command);
          ctag <= TAG_BITS'(cancel_tag);
          hp   <= 1'b0;
          priority case (cmd_t'(command))
            CMD_ENQ: begin
              strobe        <= 1'b1;
              hit_preferred <= preferred;
              hit_normal    <= !preferred;
              state         <= T_OUT;
              if ((preferred ? pcnt : ncnt) >= CNT_W'(QUEUE_DEPTH)) begin
                status  <= ST_FULL;
                tag_out <= '0;
              end else begin
                status   <= ST_ENQUEUED;
                tag_out  <= 16'(next_tag);
                last_tag <= next_tag;
              end
            end
            CMD_SERVE: begin
              if (pcnt != '0) state <= T_PQ;
              else if (ncnt != '0) state <= T_NQ;
              else begin
                strobe <= 1'b1; status <= ST_EMPTY; tag_out <= '0;
                hit_preferred <= 1'b0; hit_normal <= 1'b0;
                state <= T_OUT;
              end
            end
            default: state <= T_PQ;
          endcase
        end
        T_PQ: state <= T_WAIT;
        T_NQ: state <= T_WAIT;
        T_WAIT: begin
          if (psts.done) begin
            if (cmd == CMD_CANCEL) begin
              hp    <= psts.found;
              state <= T_NQ;
            end else begin
              strobe <= 1'b1; status <= ST_SERVED; tag_out <= 16'(psts.head);
              hit_preferred <= 1'b1; hit_normal <= 1'b0;
              state <= T_OUT;
            end
          end else if (nsts.done) begin
            strobe <= 1'b1;
            state  <= T_OUT;
            if (cmd == CMD_CANCEL) begin
              hit_preferred <= hp;
              hit_normal    <= nsts.found;
              if (hp || nsts.found) begin
                status <= ST_CANCELLED; tag_out <= 16'(ctag);
              end else begin
                status <= ST_NOT_FOUND; tag_out <= '0;
                hit_preferred <= 1'b0;
              end
            end else begin
              status <= ST_SERVED; tag_out <= 16'(nsts.head);
              hit_preferred <= 1'b0; hit_normal <= 1'b1;
            end
          end
        end
        T_OUT: state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe held");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe while idle");
  a_cnt_p: assert property (@(posedge clk) disable iff (rst)
    pcnt <= CNT_W'(QUEUE_DEPTH)) else $error("preferred overflow");
  a_cnt_n: assert property (@(posedge clk) disable iff (rst)
    ncnt <= CNT_W'(QUEUE_DEPTH)) else $error("normal overflow");
`endif
endmodule
`default_nettype wire

FILE: rtl/tcpq_fifo.sv
// one tag queue: memory with head at slot 0, compaction by read-shift-write
// depends on tcpq_pkg
`timescale 1ns / 1ps
`default_nettype none
module tcpq_fifo import tcpq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qctl_t             ctl,
  output logic [CNT_W-1:0]       count,
  output qsts_t                  sts
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIND  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } fstate_t;

  logic [TAG_BITS-1:0] mem [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] rdata;
  logic [IDX_W-1:0]    raddr;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [TAG_BITS-1:0] wdata;

  fstate_t             state, state_next;
  logic [CNT_W-1:0]    pos, pos_next;      // index whose data is in rdata in S_FIND; the slot written in S_SHIFT
  logic [CNT_W-1:0]    count_next;
  logic                found, found_next;
  logic                pop_mode;
  logic [TAG_BITS-1:0] key;
  logic [TAG_BITS-1:0] head_q;
  logic                hit;
  logic                last;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // a pop matches the head unconditionally
  assign hit  = pop_mode || (rdata == key);
  assign last = (pos + CNT_W'(1) >= count);

  always_comb begin
    state_next = state;
    pos_next   = pos;
    count_next = count;
    found_next = found;
    raddr      = '0;
    we         = 1'b0;
    waddr      = pos[IDX_W-1:0];
    wdata      = ctl.push_tag;
    unique case (state)
      S_IDLE: begin
        if (ctl.push) begin
          we         = 1'b1;
          waddr      = count[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end else if (ctl.scan || ctl.pop) begin
          // slot 0 is read here
          found_next = 1'b0;
          pos_next   = '0;
          state_next = (count == '0) ? S_DONE : S_FIND;
        end
      end
      S_FIND: begin
        // rdata holds slot pos
        if (hit) begin
          found_next = 1'b1;
          if (last) begin
            count_next = count - CNT_W'(1);
            state_next = S_DONE;
          end else begin
            raddr      = IDX_W'(pos + CNT_W'(1));
            state_next = S_SHIFT;
          end
        end else if (last) begin
          state_next = S_DONE;
        end else begin
          pos_next = pos + CNT_W'(1);
          raddr    = IDX_W'(pos + CNT_W'(1));
        end
      end
      S_SHIFT: begin
        // rdata holds slot pos+1, moved down into slot pos
        we       = 1'b1;
        wdata    = rdata;
        pos_next = pos + CNT_W'(1);
        if (pos + CNT_W'(2) >= count) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          raddr = IDX_W'(pos + CNT_W'(2));
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      found    <= 1'b0;
      pos      <= '0;
      pop_mode <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      found <= found_next;
      pos   <= pos_next;
      if (state == S_IDLE && !ctl.push && (ctl.scan || ctl.pop)) pop_mode <= ctl.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && ctl.scan) key <= ctl.key;
    if (state == S_FIND && pop_mode) head_q <= rdata;
  end

  assign sts = {state == S_DONE, found, head_q};
endmodule
`default_nettype wire
